@@ rtl/mac_pkg.sv @@
// ----------------------------------------------------------------------------
// mac_pkg
// shared types and default sizes of the moving average crossover block
// ----------------------------------------------------------------------------
package mac_pkg;

    localparam int MAC_SHORT_WINDOW = 50;
    localparam int MAC_LONG_WINDOW  = 200;
    localparam int MAC_PRICE_BITS   = 24;

    // stage load strobes of the constant divider
    typedef struct packed {
        logic ld_quo;
        logic ld_rem;
    } t_div_ctl;

endpackage

@@ rtl/mac_cdiv.sv @@
// ----------------------------------------------------------------------------
// mac_cdiv
// two-stage divide by a constant: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
module mac_cdiv
    import mac_pkg::*;
#(
    parameter int DIVISOR  = MAC_SHORT_WINDOW,
    parameter int SUM_BITS = MAC_PRICE_BITS + 8,
    parameter int QUO_BITS = MAC_PRICE_BITS
) (
    input  logic                i_clk,
    input  t_div_ctl            i_ctl,
    input  logic [SUM_BITS-1:0] i_sum,
    output logic [QUO_BITS-1:0] o_quo
);

    localparam int MW = SUM_BITS + 1;
    localparam int PW = SUM_BITS + MW;
    localparam int DW = $clog2(DIVISOR + 1);
    localparam longint unsigned RECIP_L = (64'd1 << SUM_BITS) / DIVISOR;
    localparam logic [MW-1:0]   RECIP   = MW'(RECIP_L);
    localparam logic [DW-1:0]   DIV_C   = DW'(DIVISOR);

    logic [PW-1:0]            prod;
    logic [SUM_BITS+DW-1:0]   qd;
    logic [SUM_BITS-1:0]      rem_full;
    logic [SUM_BITS-1:0]      r_q0;
    logic [SUM_BITS-1:0]      r_sum;
    logic [QUO_BITS-1:0]      r_q1;
    logic [DW:0]              r_rem;

    // estimate is the true quotient or one below it
    assign prod     = PW'(i_sum) * PW'(RECIP);
    assign qd       = (SUM_BITS + DW)'(r_q0) * (SUM_BITS + DW)'(DIV_C);
    assign rem_full = r_sum - qd[SUM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_quo) begin
            r_q0  <= prod[2*SUM_BITS-1:SUM_BITS];
            r_sum <= i_sum;
        end
        if (i_ctl.ld_rem) begin
            r_q1  <= r_q0[QUO_BITS-1:0];
            r_rem <= rem_full[DW:0];
        end
    end

    assign o_quo = (r_rem >= (DW + 1)'(DIVISOR)) ? r_q1 + QUO_BITS'(1) : r_q1;

endmodule

@@ rtl/moving_average_crossover_top.sv @@
// ----------------------------------------------------------------------------
// moving_average_crossover_top
// short and long simple moving averages of a price stream with cross flags
//
// channel  dir  fields (tdata, lsb first)
// s_axis   in   price[23:0]
// m_axis   out  short_average[23:0] short_valid long_average long_valid
//                cross_up cross_down, zero pad to 56 bits
//
// one price per cycle while m_axis_tready is high; the output is registered
// the ring memory is read at two addresses and written once per request
// synchronous active-low reset clears counters, sums, previous averages and valids
// each stage holds only when the stage after it is full and stalled
// ----------------------------------------------------------------------------
module moving_average_crossover_top
    import mac_pkg::*;
#(
    parameter int SHORT_WINDOW = MAC_SHORT_WINDOW,
    parameter int LONG_WINDOW  = MAC_LONG_WINDOW,
    parameter int PRICE_BITS   = MAC_PRICE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // price
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // short_average, short_valid, long_average, long_valid, cross_up,
    // cross_down, pad
    output logic [55:0] m_axis_tdata
);

    localparam int AW = $clog2(LONG_WINDOW);
    localparam int CW = $clog2(LONG_WINDOW + 1);
    localparam int SW = PRICE_BITS + 8;

    typedef struct packed {
        logic sv;
        logic lv;
    } t_flags;

    logic [PRICE_BITS-1:0] r_ring [LONG_WINDOW];

    logic [AW-1:0]         r_pos;
    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_short_sum;
    logic [SW-1:0]         r_long_sum;
    logic [PRICE_BITS-1:0] r_prev_sa;
    logic [PRICE_BITS-1:0] r_prev_la;
    logic                  r_prev_both;

    logic                  r_v1, r_v2, r_v3, r_v4, r_vo;
    t_flags                r_f1, r_f2, r_f3, r_f4;
    logic                  r_sub_s1, r_sub_l1;
    logic [PRICE_BITS-1:0] r_price1;
    logic [PRICE_BITS-1:0] r_rd_short;
    logic [PRICE_BITS-1:0] r_rd_long;

    logic [PRICE_BITS-1:0] r_sa, r_la;
    logic                  r_sv, r_lv, r_up, r_dn;

    logic                  rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic                  ld1, ld2, ld3, ld4, ldo;
    logic [31:0]           price_ext;
    logic [PRICE_BITS-1:0] price;
    logic [AW-1:0]         tail;
    logic [CW-1:0]         n_count;
    logic [AW-1:0]         n_pos;
    logic [SW-1:0]         n_short_sum, n_long_sum;
    t_div_ctl              div_ctl;
    logic [PRICE_BITS-1:0] quo_s, quo_l;
    logic [PRICE_BITS-1:0] sa, la;
    logic                  both;
    logic [31:0]           sa_ext, la_ext;

    // handshake chain
    assign rdy_o = !r_vo || m_axis_tready;
    assign rdy4  = !r_v4 || rdy_o;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign ld1   = s_axis_tvalid && rdy1;
    assign ld2   = r_v1 && rdy2;
    assign ld3   = r_v2 && rdy3;
    assign ld4   = r_v3 && rdy4;
    assign ldo   = r_v4 && rdy_o;
    assign s_axis_tready = rdy1;

    assign price_ext = 32'(s_axis_tdata);
    assign price     = price_ext[PRICE_BITS-1:0];

    always_comb begin
        if (r_pos >= AW'(SHORT_WINDOW)) begin
            tail = r_pos - AW'(SHORT_WINDOW);
        end else begin
            tail = r_pos + AW'(LONG_WINDOW - SHORT_WINDOW);
        end
        n_pos   = (r_pos == AW'(LONG_WINDOW - 1)) ? '0 : r_pos + AW'(1);
        n_count = (r_count < CW'(LONG_WINDOW)) ? r_count + CW'(1) : r_count;
    end

    // ring access: old entries are read before the same edge overwrites
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_rd_long     <= r_ring[r_pos];
            r_rd_short    <= r_ring[tail];
            r_ring[r_pos] <= price;
        end
    end

    always_comb begin
        n_short_sum = r_short_sum + SW'(r_price1);
        n_long_sum  = r_long_sum + SW'(r_price1);
        if (r_sub_s1) begin
            n_short_sum = n_short_sum - SW'(r_rd_short);
        end
        if (r_sub_l1) begin
            n_long_sum = n_long_sum - SW'(r_rd_long);
        end
    end

    assign div_ctl.ld_quo = ld3;
    assign div_ctl.ld_rem = ld4;

    mac_cdiv #(
        .DIVISOR  (SHORT_WINDOW),
        .SUM_BITS (SW),
        .QUO_BITS (PRICE_BITS)
    ) u_div_short (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_sum (r_short_sum),
        .o_quo (quo_s)
    );

    mac_cdiv #(
        .DIVISOR  (LONG_WINDOW),
        .SUM_BITS (SW),
        .QUO_BITS (PRICE_BITS)
    ) u_div_long (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_sum (r_long_sum),
        .o_quo (quo_l)
    );

    assign sa   = r_f4.sv ? quo_s : '0;
    assign la   = r_f4.lv ? quo_l : '0;
    assign both = r_f4.sv && r_f4.lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= '0;
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_prev_sa   <= '0;
            r_prev_la   <= '0;
            r_prev_both <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_vo        <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy_o) r_vo <= r_v4;
            if (ld1) begin
                r_pos   <= n_pos;
                r_count <= n_count;
            end
            if (ld2) begin
                r_short_sum <= n_short_sum;
                r_long_sum  <= n_long_sum;
            end
            if (ldo) begin
                r_prev_sa   <= sa;
                r_prev_la   <= la;
                r_prev_both <= both;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_price1 <= price;
            r_sub_s1 <= r_count >= CW'(SHORT_WINDOW);
            r_sub_l1 <= r_count >= CW'(LONG_WINDOW);
            r_f1.sv  <= n_count >= CW'(SHORT_WINDOW);
            r_f1.lv  <= n_count >= CW'(LONG_WINDOW);
        end
        if (ld2) r_f2 <= r_f1;
        if (ld3) r_f3 <= r_f2;
        if (ld4) r_f4 <= r_f3;
        if (ldo) begin
            r_sa <= sa;
            r_la <= la;
            r_sv <= r_f4.sv;
            r_lv <= r_f4.lv;
            r_up <= both && r_prev_both && (r_prev_la >= r_prev_sa) && (la < sa);
            r_dn <= both && r_prev_both && (r_prev_sa >= r_prev_la) && (sa < la);
        end
    end

    assign sa_ext        = 32'(r_sa);
    assign la_ext        = 32'(r_la);
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {4'b0, r_dn, r_up, r_lv, la_ext[23:0], r_sv, sa_ext[23:0]};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LONG_WINDOW))
        else $error("sample count above long window");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < (AW + 1)'(LONG_WINDOW))
        else $error("ring position out of range");

    a_wrap_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld1 && (r_pos == AW'(LONG_WINDOW - 1)) |=> r_count == CW'(LONG_WINDOW))
        else $error("ring wrapped before the long window filled");

    a_cross_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> !(r_up && r_dn))
        else $error("both cross flags set");

    a_valid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_lv |-> r_sv)
        else $error("long average valid before short average");
`endif

endmodule
